@@ sv/dcs_pkg.sv @@
// Shared constants, types and helpers for the dilated conv1d engine.
`timescale 1ns / 1ps
package dcs_pkg;

    localparam int MAX_IN_CH  = 32;
    localparam int MAX_OUT_CH = 32;
    localparam int MAX_TIME   = 16;
    localparam int MAX_TAPS   = 3;

    localparam int WEIGHT_DEPTH = MAX_OUT_CH * MAX_IN_CH * MAX_TAPS;
    localparam int SAMPLE_DEPTH = MAX_IN_CH * MAX_TIME;
    localparam int WADDR_W      = $clog2(WEIGHT_DEPTH);
    localparam int SADDR_W      = $clog2(SAMPLE_DEPTH);
    localparam int IC_W         = 5;
    localparam int OC_W         = 5;
    localparam int POS_W        = 4;
    localparam int TIME_W       = $clog2(MAX_TIME);
    localparam int TAP_W        = 2;
    localparam int ACC_W        = 40;
    localparam int PROD_W       = 32;
    localparam int RND_W        = ACC_W - 12;
    localparam int PADDR_W      = 5;

    localparam logic [1:0] OP_WEIGHT  = 2'd0;
    localparam logic [1:0] OP_BIAS    = 2'd1;
    localparam logic [1:0] OP_SAMPLE  = 2'd2;
    localparam logic [1:0] OP_COMPUTE = 2'd3;

    localparam logic [2:0] REG_IN_CH    = 3'd0;
    localparam logic [2:0] REG_OUT_CH   = 3'd1;
    localparam logic [2:0] REG_TIME     = 3'd2;
    localparam logic [2:0] REG_KERNEL   = 3'd3;
    localparam logic [2:0] REG_DILATION = 3'd4;
    localparam logic [2:0] REG_RELU     = 3'd5;

    typedef struct packed {
        logic             accept;
        logic             init;
        logic             issue;
        logic [IC_W-1:0]  ic;
        logic [TAP_W-1:0] tap;
        logic             rnd;
        logic             load;
    } dcs_cmd_t;

    typedef struct packed {
        logic item_ok;
        logic out_free;
    } dcs_sts_t;

    function automatic logic [5:0] eff_in_ch(input logic [5:0] v);
        return (v > 6'(MAX_IN_CH)) ? 6'(MAX_IN_CH) : v;
    endfunction

    function automatic logic [4:0] eff_time(input logic [4:0] v);
        return (v > 5'(MAX_TIME)) ? 5'(MAX_TIME) : v;
    endfunction

    function automatic logic [1:0] eff_taps(input logic [1:0] v);
        return (v > 2'(MAX_TAPS)) ? 2'(MAX_TAPS) : v;
    endfunction

    function automatic logic [WADDR_W-1:0] weight_addr(
        input logic [OC_W-1:0]  oc,
        input logic [IC_W-1:0]  ic,
        input logic [POS_W-1:0] tap
    );
        return (WADDR_W'(oc) * WADDR_W'(MAX_IN_CH) + WADDR_W'(ic)) * WADDR_W'(MAX_TAPS)
            + WADDR_W'(tap);
    endfunction

    function automatic logic [SADDR_W-1:0] sample_addr(
        input logic [IC_W-1:0]   ic,
        input logic [TIME_W-1:0] t
    );
        return SADDR_W'(ic) * SADDR_W'(MAX_TIME) + SADDR_W'(t);
    endfunction

endpackage

@@ sv/dilated_conv1d_same_engine_top.sv @@
// Top level of the dilated conv1d engine: register file, controller and datapath.
//
//   channel   direction  handshake               payload
//   in        in         in_valid / in_ready     opcode, out_chan, in_chan, pos, value
//   out       out        out_valid / out_ready   out_value, saturated
//   cfg       in         APB psel/penable        paddr, pwrite, pwdata, prdata
//
// Write beats leave in_ready high. A compute beat that yields a result holds it low in the
// check, run, drain1, drain2, round and finish states, the run state paced by the single
// multiply-accumulate unit stepping one channel/tap pair per cycle. When nin or nk is zero
// only check, round and finish remain; an out-of-range compute beat holds it low only in
// the check state. Reset is asynchronous, active low; stores hold garbage until written.
// A finished result waits in the output register while the next beat is accepted;
// a compute beat stalls in its last cycle only while that register is still full.
`timescale 1ns / 1ps
module dilated_conv1d_same_engine_top (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [1:0]                  opcode,
    input  logic [dcs_pkg::OC_W-1:0]    out_chan,
    input  logic [dcs_pkg::IC_W-1:0]    in_chan,
    input  logic [dcs_pkg::POS_W-1:0]   pos,
    input  logic signed [15:0]          value,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic signed [15:0]          out_value,
    output logic                        saturated,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [dcs_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import dcs_pkg::*;

    logic [5:0] in_channels_reg;
    logic [5:0] out_channels_reg;
    logic [4:0] window_len_reg;
    logic [1:0] kernel_size_reg;
    logic [3:0] dilation_reg;
    logic       relu_enable_reg;
    logic [2:0] reg_idx;
    logic       cfg_we;
    dcs_cmd_t   cmd;
    dcs_sts_t   sts;

    assign pready  = 1'b1;
    assign reg_idx = paddr[PADDR_W-1:2];
    assign cfg_we  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_channels_reg  <= 6'd32;
            out_channels_reg <= 6'd32;
            window_len_reg   <= 5'd16;
            kernel_size_reg  <= 2'd3;
            dilation_reg     <= 4'd1;
            relu_enable_reg  <= 1'b1;
        end
        else if (cfg_we)
        begin
            case (reg_idx)
                REG_IN_CH:    in_channels_reg  <= pwdata[5:0];
                REG_OUT_CH:   out_channels_reg <= pwdata[5:0];
                REG_TIME:     window_len_reg   <= pwdata[4:0];
                REG_KERNEL:   kernel_size_reg  <= pwdata[1:0];
                REG_DILATION: dilation_reg     <= pwdata[3:0];
                REG_RELU:     relu_enable_reg  <= pwdata[0];
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_IN_CH:    prdata = {26'd0, in_channels_reg};
            REG_OUT_CH:   prdata = {26'd0, out_channels_reg};
            REG_TIME:     prdata = {27'd0, window_len_reg};
            REG_KERNEL:   prdata = {30'd0, kernel_size_reg};
            REG_DILATION: prdata = {28'd0, dilation_reg};
            REG_RELU:     prdata = {31'd0, relu_enable_reg};
            default:      prdata = 32'd0;
        endcase
    end

    dcs_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .opcode      (opcode),
        .in_channels (in_channels_reg),
        .kernel_size (kernel_size_reg),
        .sts         (sts),
        .cmd         (cmd)
    );

    dcs_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .opcode       (opcode),
        .out_chan     (out_chan),
        .in_chan      (in_chan),
        .pos          (pos),
        .value        (value),
        .out_channels (out_channels_reg),
        .window_len   (window_len_reg),
        .kernel_size  (kernel_size_reg),
        .dilation     (dilation_reg),
        .relu_enable  (relu_enable_reg),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_value    (out_value),
        .saturated    (saturated)
    );

endmodule

@@ sv/dcs_ctrl.sv @@
// Controller state machine: item acceptance, channel/tap loop sequencing, result hand-off.
`timescale 1ns / 1ps
module dcs_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic [1:0]      opcode,
    input  logic [5:0]      in_channels,
    input  logic [1:0]      kernel_size,
    input  dcs_pkg::dcs_sts_t sts,
    output dcs_pkg::dcs_cmd_t cmd
);
    import dcs_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_CHECK  = 3'd1;
    localparam logic [2:0] S_RUN    = 3'd2;
    localparam logic [2:0] S_DRAIN1 = 3'd3;
    localparam logic [2:0] S_DRAIN2 = 3'd4;
    localparam logic [2:0] S_ROUND  = 3'd5;
    localparam logic [2:0] S_FINISH = 3'd6;

    logic [2:0]       state_reg, state_next;
    logic [IC_W-1:0]  c_reg, c_next;
    logic [TAP_W-1:0] k_reg, k_next;
    logic [5:0]       nin;
    logic [1:0]       nk;
    logic             last_k, last_c;

    assign nin    = eff_in_ch(in_channels);
    assign nk     = eff_taps(kernel_size);
    assign last_k = (k_reg == 2'(nk - 2'd1));
    assign last_c = ({1'b0, c_reg} == 6'(nin - 6'd1));
    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        c_next     = c_reg;
        k_next     = k_reg;
        cmd        = '0;
        cmd.accept = in_valid && in_ready;
        cmd.ic     = c_reg;
        cmd.tap    = k_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && opcode == OP_COMPUTE)
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                cmd.init = 1'b1;
                c_next   = '0;
                k_next   = '0;
                if (!sts.item_ok)
                begin
                    state_next = S_IDLE;
                end
                else if (nin == 6'd0 || nk == 2'd0)
                begin
                    state_next = S_ROUND;
                end
                else
                begin
                    state_next = S_RUN;
                end
            end
            S_RUN:
            begin
                cmd.issue = 1'b1;
                if (last_k)
                begin
                    k_next = '0;
                    c_next = c_reg + 1'b1;
                    if (last_c)
                    begin
                        state_next = S_DRAIN1;
                    end
                end
                else
                begin
                    k_next = k_reg + 1'b1;
                end
            end
            S_DRAIN1: state_next = S_DRAIN2;
            S_DRAIN2: state_next = S_ROUND;
            S_ROUND:
            begin
                cmd.rnd    = 1'b1;
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (sts.out_free)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            c_reg     <= '0;
            k_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            c_reg     <= c_next;
            k_reg     <= k_next;
        end
    end

endmodule

@@ sv/dcs_datapath.sv @@
// Datapath: weight, bias and sample stores, multiply-accumulate pipe, rounding and output register.
`timescale 1ns / 1ps
module dcs_datapath (
    input  logic                     clk,
    input  logic                     rst_n,
    input  dcs_pkg::dcs_cmd_t        cmd,
    output dcs_pkg::dcs_sts_t        sts,
    input  logic [1:0]               opcode,
    input  logic [dcs_pkg::OC_W-1:0] out_chan,
    input  logic [dcs_pkg::IC_W-1:0] in_chan,
    input  logic [dcs_pkg::POS_W-1:0] pos,
    input  logic signed [15:0]       value,
    input  logic [5:0]               out_channels,
    input  logic [4:0]               window_len,
    input  logic [1:0]               kernel_size,
    input  logic [3:0]               dilation,
    input  logic                     relu_enable,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [15:0]       out_value,
    output logic                     saturated
);
    import dcs_pkg::*;

    logic signed [15:0] weight_mem [WEIGHT_DEPTH];
    logic signed [15:0] sample_mem [SAMPLE_DEPTH];
    logic signed [15:0] bias_mem   [MAX_OUT_CH];

    logic signed [15:0]       w_q, x_q, bias_q;
    logic [OC_W-1:0]          oc_reg;
    logic [POS_W-1:0]         pos_reg;
    logic                     s1_valid_reg, s2_valid_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg, acc_sum;
    logic signed [RND_W-1:0]  rnd_reg;
    logic                     out_valid_reg;
    logic signed [15:0]       out_value_reg;
    logic                     saturated_reg;

    logic                     w_we, b_we, s_we;
    logic [4:0]               nt;
    logic [1:0]               nk, nk_m1;
    logic [5:0]               pad_full, kd;
    logic [4:0]               pad;
    logic signed [6:0]        t_val;
    logic                     t_ok;
    logic                     sat_hi, sat_lo;
    logic signed [15:0]       clamped, result;

    assign nt    = eff_time(window_len);
    assign nk    = eff_taps(kernel_size);
    assign nk_m1 = (nk == 2'd0) ? 2'd0 : 2'(nk - 2'd1);
    assign pad_full = 6'(nk_m1) * 6'(dilation);
    assign pad   = pad_full[5:1];
    assign kd    = 6'(cmd.tap) * 6'(dilation);
    assign t_val = $signed({3'b000, pos_reg}) - $signed({2'b00, pad}) + $signed({1'b0, kd});
    assign t_ok  = !t_val[6] && (t_val[5:0] < {1'b0, nt});

    assign w_we = cmd.accept && opcode == OP_WEIGHT && ({1'b0, pos} < 5'(MAX_TAPS));
    assign b_we = cmd.accept && opcode == OP_BIAS;
    assign s_we = cmd.accept && opcode == OP_SAMPLE;

    assign sts.item_ok  = ({1'b0, oc_reg} < out_channels) && ({1'b0, pos_reg} < nt);
    assign sts.out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk)
    begin
        if (w_we)
        begin
            weight_mem[weight_addr(out_chan, in_chan, pos)] <= value;
        end
        w_q <= weight_mem[weight_addr(oc_reg, cmd.ic, POS_W'(cmd.tap))];
    end

    always_ff @(posedge clk)
    begin
        if (s_we)
        begin
            sample_mem[sample_addr(in_chan, pos[TIME_W-1:0])] <= value;
        end
        x_q <= sample_mem[sample_addr(cmd.ic, t_val[TIME_W-1:0])];
    end

    always_ff @(posedge clk)
    begin
        if (b_we)
        begin
            bias_mem[out_chan] <= value;
        end
        if (cmd.accept)
        begin
            bias_q <= bias_mem[out_chan];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            oc_reg  <= out_chan;
            pos_reg <= pos;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= cmd.issue && t_ok;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    assign acc_sum = acc_reg + 40'sd2048;

    always_ff @(posedge clk)
    begin
        prod_reg <= w_q * x_q;
        if (cmd.init)
        begin
            acc_reg <= {{(ACC_W-28){bias_q[15]}}, bias_q, 12'b0};
        end
        else if (s2_valid_reg)
        begin
            acc_reg <= acc_reg + ACC_W'(prod_reg);
        end
        if (cmd.rnd)
        begin
            rnd_reg <= acc_sum[ACC_W-1:12];
        end
    end

    assign sat_hi  = rnd_reg > RND_W'(32767);
    assign sat_lo  = rnd_reg < -(RND_W'(32768));
    assign clamped = sat_hi ? 16'sh7fff : (sat_lo ? 16'sh8000 : rnd_reg[15:0]);
    assign result  = (relu_enable && clamped[15]) ? 16'sd0 : clamped;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            out_value_reg <= result;
            saturated_reg <= sat_hi || sat_lo;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_value = out_value_reg;
    assign saturated = saturated_reg;

endmodule

@@ sv/dcs_checker.sv @@
// Port-level checker for the dilated conv1d engine, bound to the top level.
`timescale 1ns / 1ps
module dcs_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_ready,
    input logic [1:0]                  opcode,
    input logic [dcs_pkg::OC_W-1:0]    out_chan,
    input logic [dcs_pkg::POS_W-1:0]   pos,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic signed [15:0]          out_value,
    input logic                        saturated,
    input logic                        psel,
    input logic                        penable,
    input logic                        pwrite,
    input logic [dcs_pkg::PADDR_W-1:0] paddr,
    input logic [31:0]                 pwdata,
    input logic                        pready
);
    import dcs_pkg::*;

    logic [1:0] pending_reg, pending_next;
    logic       relu_reg;
    logic [5:0] out_ch_reg;
    logic [4:0] win_reg;
    logic       in_compute, in_result, out_beat, cfg_we;

    assign in_compute = in_valid && in_ready && opcode == OP_COMPUTE;
    assign in_result  = in_compute && ({1'b0, out_chan} < out_ch_reg)
                        && ({1'b0, pos} < eff_time(win_reg));
    assign out_beat   = out_valid && out_ready;
    assign cfg_we     = psel && penable && pwrite && pready;

    always_comb
    begin
        pending_next = pending_reg;
        if (in_result && !out_beat)
        begin
            pending_next = pending_reg + 2'd1;
        end
        else if (!in_result && out_beat)
        begin
            pending_next = pending_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
            relu_reg    <= 1'b1;
            out_ch_reg  <= 6'd32;
            win_reg     <= 5'd16;
        end
        else
        begin
            pending_reg <= pending_next;
            if (cfg_we)
            begin
                case (paddr[PADDR_W-1:2])
                    REG_OUT_CH: out_ch_reg <= pwdata[5:0];
                    REG_TIME:   win_reg    <= pwdata[4:0];
                    REG_RELU:   relu_reg   <= pwdata[0];
                    default:    ;
                endcase
            end
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_value) && $stable(saturated))
        else $error("result beat changed while stalled");

    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pending_reg != 2'd0)
        else $error("result beat without a pending compute beat");

    a_compute_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_compute |=> !in_ready)
        else $error("input taken while a compute beat is in progress");

    a_relu: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && relu_reg |-> !out_value[15])
        else $error("negative result with rectification enabled");

    a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && saturated |->
            out_value == 16'sh7fff || out_value == 16'sh8000 || out_value == 16'sd0)
        else $error("saturated flag with an unclipped value");

endmodule

bind dilated_conv1d_same_engine_top dcs_checker u_dcs_checker (.*);

@@ tb/conv_result_checker.sv @@
// Checker for the dilated conv1d engine: tracks registers and stores, predicts and compares results.
`timescale 1ns / 1ps
module conv_result_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic                        in_ready,
    input  logic [1:0]                  opcode,
    input  logic [4:0]                  out_chan,
    input  logic [4:0]                  in_chan,
    input  logic [3:0]                  pos,
    input  logic signed [15:0]          value,
    input  logic                        out_valid,
    input  logic                        out_ready,
    input  logic signed [15:0]          out_value,
    input  logic                        saturated,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [dcs_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    input  logic [31:0]                 prdata,
    input  logic                        pready,
    output int                          errors,
    output int                          pending
);
    import dcs_pkg::*;

    typedef struct packed {
        logic signed [15:0] level;
        logic               clipped;
    } conv_out_t;

    logic signed [15:0] weight_mem [MAX_OUT_CH * MAX_IN_CH * MAX_TAPS];
    logic signed [15:0] bias_mem   [MAX_OUT_CH];
    logic signed [15:0] sample_mem [MAX_IN_CH * MAX_TIME];

    logic [5:0] in_used;
    logic [5:0] out_used;
    logic [4:0] win_len;
    logic [1:0] tap_count;
    logic [3:0] tap_step;
    logic       relu_on;

    conv_out_t expected_results [$];

    task automatic report_mismatch(input string what);
        if (errors < 100)
        begin
            $display("[%0t] MISMATCH %s", $time, what);
        end
        errors++;
    endtask

    function automatic logic conv_point(input logic [4:0] oc, input logic [3:0] t,
                                        output conv_out_t res);
        int     nin;
        int     nt;
        int     nk;
        int     dil;
        int     pad;
        int     tt;
        longint acc;
        longint rounded;
        nin = (in_used > MAX_IN_CH) ? MAX_IN_CH : int'(in_used);
        nt  = (win_len > MAX_TIME) ? MAX_TIME : int'(win_len);
        nk  = (tap_count > MAX_TAPS) ? MAX_TAPS : int'(tap_count);
        dil = int'(tap_step);
        pad = (nk > 0) ? ((nk - 1) * dil) / 2 : 0;
        res.level   = '0;
        res.clipped = 1'b0;
        if (oc >= out_used || int'(t) >= nt)
        begin
            return 1'b0;
        end
        acc = longint'(bias_mem[oc]) * 4096;
        for (int c = 0; c < nin; c++)
        begin
            for (int k = 0; k < nk; k++)
            begin
                tt = int'(t) - pad + k * dil;
                if (tt >= 0 && tt < nt)
                begin
                    acc += longint'(weight_mem[(int'(oc) * MAX_IN_CH + c) * MAX_TAPS + k])
                        * longint'(sample_mem[c * MAX_TIME + tt]);
                end
            end
        end
        rounded = (acc + 2048) >>> 12;
        if (rounded > 32767)
        begin
            rounded     = 32767;
            res.clipped = 1'b1;
        end
        else if (rounded < -32768)
        begin
            rounded     = -32768;
            res.clipped = 1'b1;
        end
        if (relu_on && rounded < 0)
        begin
            rounded = 0;
        end
        res.level = 16'(rounded);
        return 1'b1;
    endfunction

    always @(posedge clk)
    begin
        conv_out_t   want;
        logic [31:0] reg_val;
        bit          known;
        if (!rst_n)
        begin
            in_used   = 6'd32;
            out_used  = 6'd32;
            win_len   = 5'd16;
            tap_count = 2'd3;
            tap_step  = 4'd1;
            relu_on   = 1'b1;
            expected_results.delete();
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    report_mismatch($sformatf("result %0d with nothing expected",
                                              $signed(out_value)));
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (out_value !== want.level)
                    begin
                        report_mismatch($sformatf("out_value %0d, want %0d",
                                                  $signed(out_value), $signed(want.level)));
                    end
                    if (saturated !== want.clipped)
                    begin
                        report_mismatch($sformatf("saturated %b, want %b",
                                                  saturated, want.clipped));
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                case (opcode)
                    OP_WEIGHT:
                    begin
                        if (pos < MAX_TAPS)
                        begin
                            weight_mem[(int'(out_chan) * MAX_IN_CH + int'(in_chan)) * MAX_TAPS
                                + int'(pos)] = value;
                        end
                    end
                    OP_BIAS:
                    begin
                        bias_mem[out_chan] = value;
                    end
                    OP_SAMPLE:
                    begin
                        sample_mem[int'(in_chan) * MAX_TIME + int'(pos)] = value;
                    end
                    OP_COMPUTE:
                    begin
                        if (conv_point(out_chan, pos, want))
                        begin
                            expected_results.push_back(want);
                        end
                    end
                endcase
            end
            if (psel && penable && pready)
            begin
                if (pwrite)
                begin
                    case (paddr[4:2])
                        REG_IN_CH:    in_used   = pwdata[5:0];
                        REG_OUT_CH:   out_used  = pwdata[5:0];
                        REG_TIME:     win_len   = pwdata[4:0];
                        REG_KERNEL:   tap_count = pwdata[1:0];
                        REG_DILATION: tap_step  = pwdata[3:0];
                        REG_RELU:     relu_on   = pwdata[0];
                        default:      ;
                    endcase
                end
                else
                begin
                    known = 1'b1;
                    reg_val = '0;
                    case (paddr[4:2])
                        REG_IN_CH:    reg_val = {26'd0, in_used};
                        REG_OUT_CH:   reg_val = {26'd0, out_used};
                        REG_TIME:     reg_val = {27'd0, win_len};
                        REG_KERNEL:   reg_val = {30'd0, tap_count};
                        REG_DILATION: reg_val = {28'd0, tap_step};
                        REG_RELU:     reg_val = {31'd0, relu_on};
                        default:      known = 1'b0;
                    endcase
                    if (known && prdata !== reg_val)
                    begin
                        report_mismatch($sformatf("register %0d reads %0h, want %0h",
                                                  paddr[4:2], prdata, reg_val));
                    end
                end
            end
        end
        pending = expected_results.size();
    end

endmodule

@@ tb/testbench.sv @@
// Testbench top: clock, reset, stimulus and verdict for the dilated conv1d engine.
`timescale 1ns / 1ps
module testbench;
    import dcs_pkg::*;

    localparam int         QUIET_LIMIT = 5000;
    localparam int         LONG_HOLD   = 400;
    localparam int         SETTLE      = 120;
    localparam int         ITEM_TARGET = 1450;
    localparam logic [2:0] REG_SPARE_A = 3'd6;
    localparam logic [2:0] REG_SPARE_B = 3'd7;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    logic [1:0]          opcode;
    logic [OC_W-1:0]     out_chan;
    logic [IC_W-1:0]     in_chan;
    logic [POS_W-1:0]    pos;
    logic signed [15:0]  value;
    logic                out_valid;
    logic                out_ready;
    logic signed [15:0]  out_value;
    logic                saturated;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;

    int errors;
    int pending;
    int quiet_cycles = 0;
    int beats_sent = 0;
    bit tx_gaps_on;
    bit rx_gaps_on;
    bit hold_rx;

    logic [5:0] cur_in;
    logic [5:0] cur_out;
    logic [4:0] cur_time;
    logic [1:0] cur_taps;
    logic [3:0] cur_dil;

    bit wt_loaded   [MAX_OUT_CH][MAX_IN_CH][MAX_TAPS];
    bit bias_loaded [MAX_OUT_CH];
    bit smp_loaded  [MAX_IN_CH][MAX_TIME];

    dilated_conv1d_same_engine_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .opcode    (opcode),
        .out_chan  (out_chan),
        .in_chan   (in_chan),
        .pos       (pos),
        .value     (value),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_value (out_value),
        .saturated (saturated),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    conv_result_checker conv_check (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .opcode    (opcode),
        .out_chan  (out_chan),
        .in_chan   (in_chan),
        .pos       (pos),
        .value     (value),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_value (out_value),
        .saturated (saturated),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .errors    (errors),
        .pending   (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        int rx_gap;
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (hold_rx)
            begin
                hold_rx = 1'b0;
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
            end
            else if (rx_gaps_on)
            begin
                rx_gap = $urandom_range(0, 18);
                if (rx_gap > 0)
                begin
                    out_ready <= 1'b0;
                    repeat (rx_gap) @(negedge clk);
                end
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
        end
    end

    function automatic logic [15:0] rand_word();
        case ($urandom_range(0, 9))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2, 3, 4: return 16'($urandom);
            default: return 16'($urandom_range(0, 2047)) - 16'd1024;
        endcase
    endfunction

    function automatic int draw_extent(input int top, input int field_max, input int usual_hi);
        case ($urandom_range(0, 9))
            0:       return 0;
            1:       return top;
            2:       return $urandom_range(top + 1, field_max);
            default: return $urandom_range(1, usual_hi);
        endcase
    endfunction

    task automatic send_beat(input logic [1:0] op, input logic [4:0] oc, input logic [4:0] ic,
                             input logic [3:0] p, input logic [15:0] v);
        int gap;
        gap = tx_gaps_on ? $urandom_range(0, 18) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        opcode   <= op;
        out_chan <= oc;
        in_chan  <= ic;
        pos      <= p;
        value    <= v;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        case (op)
            OP_WEIGHT:
            begin
                if (p < MAX_TAPS)
                begin
                    wt_loaded[oc][ic][p] = 1'b1;
                    beats_sent++;
                end
            end
            OP_BIAS:
            begin
                bias_loaded[oc] = 1'b1;
                beats_sent++;
            end
            OP_SAMPLE:
            begin
                smp_loaded[ic][p] = 1'b1;
                beats_sent++;
            end
            OP_COMPUTE:
            begin
                beats_sent++;
            end
        endcase
    endtask

    task automatic apb_access(input logic wr, input logic [2:0] idx, input logic [31:0] data);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic quiesce();
        @(negedge clk);
        in_valid <= 1'b0;
        wait (pending == 0);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic set_config(input logic [5:0] n_in, input logic [5:0] n_out,
                              input logic [4:0] n_time, input logic [1:0] n_taps,
                              input logic [3:0] n_dil, input logic relu);
        apb_access(1'b1, REG_IN_CH, {26'($urandom), n_in});
        apb_access(1'b1, REG_OUT_CH, {26'($urandom), n_out});
        apb_access(1'b1, REG_TIME, {27'($urandom), n_time});
        apb_access(1'b1, REG_KERNEL, {30'($urandom), n_taps});
        apb_access(1'b1, REG_DILATION, {28'($urandom), n_dil});
        apb_access(1'b1, REG_RELU, {31'($urandom), relu});
        if ($urandom_range(0, 1) != 0)
        begin
            apb_access(1'b1, ($urandom_range(0, 1) != 0) ? REG_SPARE_A : REG_SPARE_B, $urandom);
        end
        apb_access(1'b0, REG_IN_CH, $urandom);
        apb_access(1'b0, REG_OUT_CH, $urandom);
        apb_access(1'b0, REG_TIME, $urandom);
        apb_access(1'b0, REG_KERNEL, $urandom);
        apb_access(1'b0, REG_DILATION, $urandom);
        apb_access(1'b0, REG_RELU, $urandom);
        cur_in   = n_in;
        cur_out  = n_out;
        cur_time = n_time;
        cur_taps = n_taps;
        cur_dil  = n_dil;
    endtask

    task automatic compute_point(input logic [4:0] oc, input logic [3:0] t);
        int nin;
        int nt;
        int nk;
        int dil;
        int pad;
        int tt;
        nin = (cur_in > MAX_IN_CH) ? MAX_IN_CH : int'(cur_in);
        nt  = (cur_time > MAX_TIME) ? MAX_TIME : int'(cur_time);
        nk  = (cur_taps > MAX_TAPS) ? MAX_TAPS : int'(cur_taps);
        dil = int'(cur_dil);
        pad = (nk > 0) ? ((nk - 1) * dil) / 2 : 0;
        if (oc < cur_out && int'(t) < nt)
        begin
            if (!bias_loaded[oc])
            begin
                send_beat(OP_BIAS, oc, 5'($urandom), 4'($urandom), rand_word());
            end
            for (int c = 0; c < nin; c++)
            begin
                for (int k = 0; k < nk; k++)
                begin
                    tt = int'(t) - pad + k * dil;
                    if (tt >= 0 && tt < nt)
                    begin
                        if (!wt_loaded[oc][c][k])
                        begin
                            send_beat(OP_WEIGHT, oc, 5'(c), 4'(k), rand_word());
                        end
                        if (!smp_loaded[c][tt])
                        begin
                            send_beat(OP_SAMPLE, 5'($urandom), 5'(c), 4'(tt), rand_word());
                        end
                    end
                end
            end
        end
        send_beat(OP_COMPUTE, oc, 5'($urandom), t, 16'($urandom));
    endtask

    task automatic random_write();
        logic [1:0] op;
        logic [3:0] p;
        case ($urandom_range(0, 2))
            0:       op = OP_WEIGHT;
            1:       op = OP_BIAS;
            default: op = OP_SAMPLE;
        endcase
        p = 4'($urandom);
        if (op == OP_WEIGHT && $urandom_range(0, 3) != 0)
        begin
            p = 4'($urandom_range(0, MAX_TAPS - 1));
        end
        send_beat(op, 5'($urandom), 5'($urandom), p, rand_word());
    endtask

    task automatic phase(input logic [5:0] n_in, input logic [5:0] n_out,
                         input logic [4:0] n_time, input logic [1:0] n_taps,
                         input logic [3:0] n_dil, input logic relu, input int n);
        int         start;
        int         nt;
        logic [4:0] oc;
        logic [3:0] t;
        quiesce();
        set_config(n_in, n_out, n_time, n_taps, n_dil, relu);
        tx_gaps_on = ($urandom_range(0, 3) != 0);
        rx_gaps_on = ($urandom_range(0, 3) != 0);
        nt = (cur_time > MAX_TIME) ? MAX_TIME : int'(cur_time);
        start = beats_sent;
        while (beats_sent - start < n)
        begin
            if ($urandom_range(0, 9) < 7)
            begin
                oc = ($urandom_range(0, 6) != 0) ? 5'($urandom_range(0, 3)) : 5'($urandom);
                t = ($urandom_range(0, 6) != 0 && nt > 0) ? 4'($urandom_range(0, nt - 1))
                                                          : 4'($urandom);
                compute_point(oc, t);
            end
            else
            begin
                random_write();
            end
        end
    endtask

    initial
    begin
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        opcode     = OP_WEIGHT;
        out_chan   = '0;
        in_chan    = '0;
        pos        = '0;
        value      = '0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        tx_gaps_on = 1'b0;
        rx_gaps_on = 1'b0;
        hold_rx    = 1'b0;
        cur_in     = 6'd32;
        cur_out    = 6'd32;
        cur_time   = 5'd16;
        cur_taps   = 2'd3;
        cur_dil    = 4'd1;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        set_config(6'd1, 6'd2, 5'd4, 2'd3, 4'd1, 1'b0);
        send_beat(OP_WEIGHT, 5'd0, 5'd0, 4'd0, 16'h7FFF);
        send_beat(OP_WEIGHT, 5'd0, 5'd0, 4'd1, 16'h8000);
        send_beat(OP_WEIGHT, 5'd0, 5'd0, 4'd2, 16'h0001);
        send_beat(OP_WEIGHT, 5'd0, 5'd0, 4'd3, 16'h1234);
        send_beat(OP_WEIGHT, 5'd31, 5'd31, 4'd15, 16'hFFFF);
        send_beat(OP_WEIGHT, 5'd31, 5'd31, 4'd2, 16'h8000);
        send_beat(OP_BIAS, 5'd0, 5'd31, 4'd15, 16'h7FFF);
        send_beat(OP_BIAS, 5'd31, 5'd0, 4'd0, 16'h8000);
        send_beat(OP_SAMPLE, 5'd31, 5'd0, 4'd0, 16'h7FFF);
        send_beat(OP_SAMPLE, 5'd0, 5'd0, 4'd1, 16'h8000);
        send_beat(OP_SAMPLE, 5'd0, 5'd0, 4'd2, 16'h0100);
        send_beat(OP_SAMPLE, 5'd0, 5'd0, 4'd3, 16'hFFFF);
        send_beat(OP_SAMPLE, 5'd0, 5'd31, 4'd15, 16'h8000);
        for (int t = 0; t < 4; t++)
        begin
            compute_point(5'd0, 4'(t));
        end
        compute_point(5'd1, 4'd0);
        compute_point(5'd31, 4'd0);
        compute_point(5'd0, 4'd15);

        quiesce();
        set_config(6'd2, 6'd2, 5'd8, 2'd3, 4'd2, 1'b1);
        tx_gaps_on = 1'b0;
        rx_gaps_on = 1'b0;
        hold_rx    = 1'b1;
        for (int i = 0; i < 8; i++)
        begin
            compute_point(5'(i % 2), 4'(i));
        end

        phase(6'd32, 6'd32, 5'd16, 2'd3, 4'd8, 1'b1, 250);
        phase(6'd1, 6'd1, 5'd1, 2'd1, 4'd1, 1'b0, 40);
        phase(6'd0, 6'd40, 5'd31, 2'd0, 4'd0, 1'b1, 40);
        phase(6'd63, 6'd0, 5'd0, 2'd2, 4'd15, 1'b0, 30);
        phase(6'd3, 6'd63, 5'd17, 2'd2, 4'd0, 1'b0, 60);
        while (beats_sent < ITEM_TARGET)
        begin
            phase(6'(draw_extent(MAX_IN_CH, 63, 4)), 6'(draw_extent(MAX_OUT_CH, 63, 4)),
                  5'(draw_extent(MAX_TIME, 31, MAX_TIME)), 2'($urandom_range(0, 3)),
                  ($urandom_range(0, 4) == 0) ? 4'($urandom_range(9, 15))
                                              : 4'($urandom_range(0, 8)),
                  1'($urandom_range(0, 1)), $urandom_range(30, 90));
        end
        quiesce();

        if (errors == 0 && pending == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
